### design/assert_macros.svh
// Assertion macros for the RTL, included by euler_to_quaternion.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/eq_pkg.sv
// Types and constants for the Euler angle to quaternion block.
// No dependencies; used by eq_lane, eq_merge and euler_to_quaternion.
package eq_pkg;

	typedef struct packed {
		logic signed [15:0] angle_first;
		logic signed [15:0] angle_second;
		logic signed [15:0] angle_third;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	// Q2.30 datapath word, with headroom for the CORDIC residual
	typedef logic signed [33:0] q30_t;

	localparam q30_t Q30_PI      = 34'sd3373259426;
	localparam q30_t Q30_HALF_PI = 34'sd1686629713;
	localparam q30_t CORDIC_GAIN = 34'sd652032874;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;
	localparam logic [1:0] AXIS_UNUSED = 2'd3;

	localparam int ATAN_DEPTH = 32;
	localparam q30_t ATAN_Q30 [0:ATAN_DEPTH-1] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
		34'sd67021687, 34'sd33543515, 34'sd16775851, 34'sd8388438,
		34'sd4194283, 34'sd2097150, 34'sd1048576, 34'sd524288,
		34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
		34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
		34'sd1024, 34'sd512, 34'sd256, 34'sd128,
		34'sd64, 34'sd32, 34'sd16, 34'sd8,
		34'sd4, 34'sd2, 34'sd1, 34'sd0
	};

	// cyclic successor of an axis, indexed by axis plus offset (0..3)
	function automatic logic [1:0] eq_next_axis(input logic [2:0] idx);
		logic [1:0] r;
		case (idx)
			3'd0: r = AXIS_Y;
			3'd1: r = AXIS_Z;
			3'd2: r = AXIS_X;
			3'd3: r = AXIS_Y;
			default: r = AXIS_X;
		endcase
		return r;
	endfunction

endpackage

### design/euler_to_quaternion.sv
// Euler angles to unit quaternion, all 24 axis orders, top level.
// Depends on eq_pkg, eq_lane, eq_merge and assert_macros.svh.
//
// Takes three Q2.13 angles per word and returns one Q1.14 quaternion word
// (w, x, y, z), saturated to +/-1.0. The axis order sits in a 5-bit register
// written through the cfg port: bit 0 frame (1 = rotating, swaps first and
// third angles), bit 1 repetition, bit 2 parity (odd negates the second angle
// and the middle component), bits 4:3 first axis (x, y, z; code 3 acts as x).
// Three CORDIC lanes run side by side, one per angle, each with one pipeline
// stage per iteration; a four-stage merge forms the products and sums.
// Throughput is one word per cycle while the output is not stalled. A word
// passes each lane's input register and iteration stages, then the merge
// stages. The whole pipeline moves together and holds while a finished
// result waits on quat_ready, so input is stalled only while the output is
// stalled. Write the register only while no word is in flight.
module euler_to_quaternion #(
	parameter int ANGLE_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            angles_valid,
	output logic            angles_ready,
	input  eq_pkg::angles_t angles,
	output logic            quat_valid,
	input  logic            quat_ready,
	output eq_pkg::quat_t   quat,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [4:0]      cfg_data
);
	import eq_pkg::*;

	`include "assert_macros.svh"

	logic [4:0] order_q;
	logic       en;
	logic       frame;
	logic signed [15:0] ang_a;
	logic signed [15:0] ang_c;
	logic       v_a, v_b, v_c;
	q30_t       ci, si, cj, sj, ch, sh;

	// register always accepts; the user must write only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
		end else if (cfg_valid) begin
			order_q <= cfg_data;
		end
	end

	// whole pipeline advances unless a result is stuck at the output
	assign en = !quat_valid || quat_ready;
	assign angles_ready = en;

	// rotating frame swaps first and third angles
	assign frame = order_q[0];
	assign ang_a = frame ? angles.angle_third : angles.angle_first;
	assign ang_c = frame ? angles.angle_first : angles.angle_third;

	eq_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_a (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(angles_valid),
		.angle(ang_a), .valid_out(v_a), .cos_out(ci), .sin_out(si)
	);

	eq_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_b (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(angles_valid),
		.angle(angles.angle_second), .valid_out(v_b), .cos_out(cj), .sin_out(sj)
	);

	eq_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_c (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(angles_valid),
		.angle(ang_c), .valid_out(v_c), .cos_out(ch), .sin_out(sh)
	);

	eq_merge u_merge (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(v_a), .order(order_q),
		.ci(ci), .si(si), .cj(cj), .sj(sj), .ch(ch), .sh(sh),
		.valid_out(quat_valid), .quat(quat)
	);

	// lanes share one enable, so their valid chains never drift apart
	`EQ_ASSERT_NOW(a_lanes_aligned, 1'b1, (v_a == v_b) && (v_a == v_c), "lane valids differ")
	`EQ_ASSERT_NOW(a_stall_blocks_input, quat_valid && !quat_ready, !angles_ready,
		"input taken while output stalled")
	`EQ_ASSERT_NOW(a_w_range, quat_valid,
		(quat.quat_w <= 16'sd16384) && (quat.quat_w >= -16'sd16384), "w out of range")

endmodule

### design/eq_lane.sv
// One CORDIC lane: half-angle sine and cosine of a Q2.13 angle, in Q2.30.
// Depends on eq_pkg. One pipeline stage per CORDIC iteration.
module eq_lane #(
	parameter int ANGLE_WIDTH   = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  logic signed [15:0]  angle,
	output logic                valid_out,
	output eq_pkg::q30_t        cos_out,
	output eq_pkg::q30_t        sin_out
);
	import eq_pkg::*;

	localparam int NS = (CORDIC_STAGES > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STAGES;
	localparam int FLOOR_BITS = (ANGLE_WIDTH < 16) ? (32 - ANGLE_WIDTH) : 0;
	localparam logic [33:0] ZMASK = ~((34'd1 << FLOOR_BITS) - 34'd1);

	q30_t x_s [0:NS];
	q30_t y_s [0:NS];
	q30_t z_s [0:NS];
	logic neg_s [0:NS];
	logic vld_s [0:NS];

	q30_t z_in;
	q30_t z_red;
	logic neg_in;

	// half angle is angle * 2^16 in Q2.30, then folded into [-pi/2, pi/2]
	always_comb begin
		z_in = $signed({{2{angle[15]}}, angle, 16'd0} & ZMASK);
		z_red = z_in;
		neg_in = 1'b0;
		if (z_in > Q30_HALF_PI) begin
			z_red = z_in - Q30_PI;
			neg_in = 1'b1;
		end else if (z_in < -Q30_HALF_PI) begin
			z_red = z_in + Q30_PI;
			neg_in = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= z_red;
			neg_s[0] <= neg_in;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_stage
		q30_t xsh;
		q30_t ysh;
		assign xsh = x_s[g] >>> g;
		assign ysh = y_s[g] >>> g;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[g+1] <= neg_s[g];
				if (!z_s[g][33]) begin
					x_s[g+1] <= x_s[g] - ysh;
					y_s[g+1] <= y_s[g] + xsh;
					z_s[g+1] <= z_s[g] - ATAN_Q30[g];
				end else begin
					x_s[g+1] <= x_s[g] + ysh;
					y_s[g+1] <= y_s[g] - xsh;
					z_s[g+1] <= z_s[g] + ATAN_Q30[g];
				end
			end
		end
	end

	assign valid_out = vld_s[NS];
	assign cos_out = neg_s[NS] ? -x_s[NS] : x_s[NS];
	assign sin_out = neg_s[NS] ? -y_s[NS] : y_s[NS];

endmodule

### design/eq_merge.sv
// Merge stage: combines the three lanes' sines and cosines into (w, x, y, z).
// Depends on eq_pkg. Four stages: products, operand select, multiply, sum/round.
module eq_merge (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic [4:0]    order,
	input  eq_pkg::q30_t  ci,
	input  eq_pkg::q30_t  si,
	input  eq_pkg::q30_t  cj,
	input  eq_pkg::q30_t  sj,
	input  eq_pkg::q30_t  ch,
	input  eq_pkg::q30_t  sh,
	output logic          valid_out,
	output eq_pkg::quat_t quat
);
	import eq_pkg::*;

	typedef struct packed {
		logic signed [33:0] a;
		logic signed [34:0] b;
		logic signed [33:0] c;
		logic signed [34:0] d;
	} terms_t;

	typedef logic signed [71:0] wide_t;

	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [67:0] p;
		p = (68'(a) * 68'(b) + 68'sd536870912) >>> 30;
		return p[33:0];
	endfunction

	function automatic logic signed [15:0] to_q14(input wide_t v);
		wide_t r;
		r = (v + (72'sd1 <<< 45)) >>> 46;
		if (r > 72'sd16384) begin
			r = 72'sd16384;
		end else if (r < -72'sd16384) begin
			r = -72'sd16384;
		end
		return r[15:0];
	endfunction

	logic       rep;
	logic       par;
	logic [1:0] ax_i;
	logic [1:0] ax_j;

	always_comb begin
		rep = order[1];
		par = order[2];
		ax_i = (order[4:3] == AXIS_UNUSED) ? AXIS_X : order[4:3];
		ax_j = eq_next_axis(3'(ax_i) + 3'(par));
	end

	// stage 1: cross products of first and third half angles
	logic v_s1;
	q30_t cc_s1, cs_s1, sc_s1, ss_s1, cj_s1, sj_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1 <= mul_q30(ci, ch);
			cs_s1 <= mul_q30(ci, sh);
			sc_s1 <= mul_q30(si, ch);
			ss_s1 <= mul_q30(si, sh);
			cj_s1 <= cj;
			sj_s1 <= par ? -sj : sj;
		end
	end

	// stage 2: operand select; result = a*b + c*d per component
	terms_t t_i, t_j, t_k, t_w;
	logic signed [34:0] cc35, cs35, sc35, ss35;

	always_comb begin
		cc35 = 35'(cc_s1);
		cs35 = 35'(cs_s1);
		sc35 = 35'(sc_s1);
		ss35 = 35'(ss_s1);
		if (rep) begin
			t_i = '{a: cj_s1, b: cs35 + sc35, c: '0, d: '0};
			t_j = '{a: sj_s1, b: cc35 + ss35, c: '0, d: '0};
			t_k = '{a: sj_s1, b: cs35 - sc35, c: '0, d: '0};
			t_w = '{a: cj_s1, b: cc35 - ss35, c: '0, d: '0};
		end else begin
			t_i = '{a: cj_s1, b: sc35, c: sj_s1, d: -cs35};
			t_j = '{a: cj_s1, b: ss35, c: sj_s1, d: cc35};
			t_k = '{a: cj_s1, b: cs35, c: sj_s1, d: -sc35};
			t_w = '{a: cj_s1, b: cc35, c: sj_s1, d: ss35};
		end
		// odd parity flips the middle component
		if (par) begin
			t_j.b = -t_j.b;
			t_j.d = -t_j.d;
		end
	end

	logic v_s2;
	terms_t w_s2;
	terms_t ax_s2 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2 <= t_w;
			for (int n = 0; n < 3; n++) begin
				if (2'(n) == ax_i) begin
					ax_s2[n] <= t_i;
				end else if (2'(n) == ax_j) begin
					ax_s2[n] <= t_j;
				end else begin
					ax_s2[n] <= t_k;
				end
			end
		end
	end

	// stage 3: multiplies
	logic v_s3;
	wide_t p1_s3 [0:3];
	wide_t p2_s3 [0:3];
	terms_t tsel [0:3];

	always_comb begin
		tsel[0] = w_s2;
		tsel[1] = ax_s2[0];
		tsel[2] = ax_s2[1];
		tsel[3] = ax_s2[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 4; n++) begin
				p1_s3[n] <= 72'(tsel[n].a) * 72'(tsel[n].b);
				p2_s3[n] <= 72'(tsel[n].c) * 72'(tsel[n].d);
			end
		end
	end

	// stage 4: sum, round to Q1.14, saturate
	logic v_s4;
	quat_t q_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4.quat_w <= to_q14(p1_s3[0] + p2_s3[0]);
			q_s4.quat_x <= to_q14(p1_s3[1] + p2_s3[1]);
			q_s4.quat_y <= to_q14(p1_s3[2] + p2_s3[2]);
			q_s4.quat_z <= to_q14(p1_s3[3] + p2_s3[3]);
		end
	end

	assign valid_out = v_s4;
	assign quat = q_s4;

endmodule
